// ===== hw/rtl/apf_pkg.sv =====
// ----------------------------------------------------------------------------
// apf_pkg
// Shared types, request codes and defaults of the articulation point finder.
// ----------------------------------------------------------------------------
package apf_pkg;

   localparam int DEF_MAX_VERTICES = 64;
   localparam int DEF_MAX_EDGES    = 256;
   localparam int END_W            = 6;
   localparam int VCNT_W           = 7;
   localparam logic [VCNT_W-1:0] VCOUNT_RESET = 7'd64;

   localparam logic [1:0] FUNC_ADD     = 2'd0;
   localparam logic [1:0] FUNC_ADD_RUN = 2'd1;
   localparam logic [1:0] FUNC_RUN     = 2'd2;

   typedef struct packed {
      logic [1:0]       func;
      logic [END_W-1:0] end_a;
      logic [END_W-1:0] end_b;
   } req_type;

   typedef struct packed {
      logic [END_W-1:0]  cut_vertex;
      logic [VCNT_W-1:0] point_count;
      logic              none_found;
      logic              edge_overflow;
      logic              last_result;
   } rsp_type;

   typedef struct packed {
      logic run;
      logic dropped;
   } run_ctl_type;

   typedef enum logic [3:0] {
      S_IDLE, S_START, S_ROOT, S_EREAD, S_EDGE, S_NBR, S_POPW, S_COUNT, S_EMIT
   } walk_state_type;

endpackage

// ===== hw/rtl/apf_ram.sv =====
// ----------------------------------------------------------------------------
// apf_ram
// Single write port, single read port memory with registered read data.
// ----------------------------------------------------------------------------
module apf_ram #(
   parameter int DEPTH = 64,
   parameter int WIDTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/apf_search.sv =====
// ----------------------------------------------------------------------------
// apf_search
// Depth-first cut vertex search over the edge store, then result emission.
// ----------------------------------------------------------------------------
module apf_search
   import apf_pkg::*;
#(
   parameter int MAX_VERTICES = DEF_MAX_VERTICES,
   parameter int MAX_EDGES    = DEF_MAX_EDGES
) (
   input  logic                           clock,
   input  logic                           reset,
   input  run_ctl_type                    ctl,
   input  logic [$clog2(MAX_VERTICES+1)-1:0] n_vert,
   input  logic [$clog2(MAX_EDGES+1)-1:0] edges_loaded,
   output logic [$clog2(MAX_EDGES)-1:0]   edge_raddr,
   input  logic [2*END_W-1:0]             edge_rdata,
   output logic                           busy,
   output logic                           finish,
   output logic                           rsp_strobe,
   output rsp_type                        rsp_data
);

   localparam int VW  = $clog2(MAX_VERTICES);
   localparam int NW  = $clog2(MAX_VERTICES+1);
   localparam int TW  = $clog2(MAX_VERTICES+2);
   localparam int EAW = $clog2(MAX_EDGES);
   localparam int ECW = $clog2(MAX_EDGES+1);

   typedef struct packed {
      logic [VW-1:0]  vtx;
      logic [VW-1:0]  par;
      logic           has_par;
      logic [ECW-1:0] next;
      logic [NW-1:0]  kids;
      logic [TW-1:0]  disc;
      logic [TW-1:0]  low;
   } frame_type;

   localparam int FW = $bits(frame_type);

   walk_state_type state_ff, state_in;
   frame_type top_ff, top_in;
   logic [VW-1:0] sp_ff, sp_in;
   logic [NW-1:0] scan_ff, scan_in;
   logic [TW-1:0] time_ff, time_in;
   logic [NW-1:0] count_ff, count_in;
   logic [NW-1:0] k_ff, k_in;
   logic [VW-1:0] nb_ff, nb_in;
   logic [TW-1:0] clow_ff, clow_in;
   logic ovf_ff, ovf_in;
   logic [MAX_VERTICES-1:0] vis_ff, vis_in, cut_ff, cut_in;
   logic rsp_strobe_ff, rsp_strobe_in;
   rsp_type rsp_data_ff, rsp_data_in;

   logic st_we, dm_we;
   logic [VW-1:0] st_waddr, st_raddr, dm_addr, dm_raddr;
   logic [FW-1:0] st_rdata;
   logic [TW-1:0] dm_rdata;
   frame_type parent;
   logic [END_W-1:0] ea, eb;
   logic [VW-1:0] nb;
   logic [VW-1:0] scan_v;

   apf_ram #(.DEPTH(MAX_VERTICES), .WIDTH(FW)) u_stack (
      .clock(clock), .wr_en(st_we), .wr_addr(st_waddr), .wr_data(top_ff),
      .rd_addr(st_raddr), .rd_data(st_rdata)
   );

   apf_ram #(.DEPTH(MAX_VERTICES), .WIDTH(TW)) u_disc (
      .clock(clock), .wr_en(dm_we), .wr_addr(dm_addr), .wr_data(time_ff),
      .rd_addr(dm_raddr), .rd_data(dm_rdata)
   );

   assign parent = frame_type'(st_rdata);
   assign ea = edge_rdata[2*END_W-1:END_W];
   assign eb = edge_rdata[END_W-1:0];
   assign nb = (VW'(ea) == top_ff.vtx) ? VW'(eb) : VW'(ea);
   assign scan_v = scan_ff[VW-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         rsp_strobe_ff <= 1'b0;
         vis_ff        <= '0;
         cut_ff        <= '0;
      end else begin
         state_ff      <= state_in;
         rsp_strobe_ff <= rsp_strobe_in;
         vis_ff        <= vis_in;
         cut_ff        <= cut_in;
      end
   end

   always_ff @(posedge clock) begin
      top_ff      <= top_in;
      sp_ff       <= sp_in;
      scan_ff     <= scan_in;
      time_ff     <= time_in;
      count_ff    <= count_in;
      k_ff        <= k_in;
      nb_ff       <= nb_in;
      clow_ff     <= clow_in;
      ovf_ff      <= ovf_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_comb begin
      state_in      = state_ff;
      top_in        = top_ff;
      sp_in         = sp_ff;
      scan_in       = scan_ff;
      time_in       = time_ff;
      count_in      = count_ff;
      k_in          = k_ff;
      nb_in         = nb_ff;
      clow_in       = clow_ff;
      ovf_in        = ovf_ff;
      vis_in        = vis_ff;
      cut_in        = cut_ff;
      rsp_strobe_in = 1'b0;
      rsp_data_in   = rsp_data_ff;
      st_we         = 1'b0;
      st_waddr      = sp_ff;
      st_raddr      = sp_ff - VW'(1);
      dm_we         = 1'b0;
      dm_addr       = nb;
      dm_raddr      = nb;
      edge_raddr    = top_ff.next[EAW-1:0];
      finish        = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (ctl.run) begin
               state_in = S_START;
               ovf_in   = ctl.dropped;
            end
         end
         S_START: begin
            vis_in   = '0;
            cut_in   = '0;
            time_in  = TW'(1);
            scan_in  = '0;
            state_in = S_ROOT;
         end
         S_ROOT: begin
            if (scan_ff >= n_vert) begin
               scan_in  = '0;
               count_in = '0;
               state_in = S_COUNT;
            end else if (!vis_ff[scan_v]) begin
               top_in          = '0;
               top_in.vtx      = scan_v;
               top_in.disc     = time_ff;
               top_in.low      = time_ff;
               sp_in           = '0;
               dm_we           = 1'b1;
               dm_addr         = scan_v;
               vis_in[scan_v]  = 1'b1;
               time_in         = time_ff + TW'(1);
               state_in        = S_EREAD;
            end else begin
               scan_in = scan_ff + NW'(1);
            end
         end
         S_EREAD: begin
            if (top_ff.next < edges_loaded) begin
               top_in.next = top_ff.next + ECW'(1);
               state_in    = S_EDGE;
            end else if (sp_ff == '0) begin
               if (top_ff.kids > NW'(1)) begin
                  cut_in[top_ff.vtx] = 1'b1;
               end
               scan_in  = scan_ff + NW'(1);
               state_in = S_ROOT;
            end else begin
               sp_in    = sp_ff - VW'(1);
               clow_in  = top_ff.low;
               state_in = S_POPW;
            end
         end
         S_EDGE: begin
            state_in = S_EREAD;
            if ((int'(ea) < int'(n_vert)) && (int'(eb) < int'(n_vert)) &&
                ((VW'(ea) == top_ff.vtx) || (VW'(eb) == top_ff.vtx)) &&
                !(top_ff.has_par && (nb == top_ff.par))) begin
               nb_in = nb;
               if (vis_ff[nb]) begin
                  state_in = S_NBR;
               end else if (int'(sp_ff) + 1 < MAX_VERTICES) begin
                  st_we          = 1'b1;
                  sp_in          = sp_ff + VW'(1);
                  top_in         = '0;
                  top_in.vtx     = nb;
                  top_in.par     = top_ff.vtx;
                  top_in.has_par = 1'b1;
                  top_in.disc    = time_ff;
                  top_in.low     = time_ff;
                  dm_we          = 1'b1;
                  vis_in[nb]     = 1'b1;
                  time_in        = time_ff + TW'(1);
               end
            end
         end
         S_NBR: begin
            if (dm_rdata < top_ff.low) begin
               top_in.low = dm_rdata;
            end
            state_in = S_EREAD;
         end
         S_POPW: begin
            top_in      = parent;
            top_in.kids = parent.kids + NW'(1);
            if (clow_ff < parent.low) begin
               top_in.low = clow_ff;
            end
            if (parent.has_par && (clow_ff >= parent.disc)) begin
               cut_in[parent.vtx] = 1'b1;
            end
            state_in = S_EREAD;
         end
         S_COUNT: begin
            if (scan_ff >= n_vert) begin
               scan_in  = '0;
               k_in     = '0;
               state_in = S_EMIT;
            end else begin
               count_in = count_ff + NW'(cut_ff[scan_v]);
               scan_in  = scan_ff + NW'(1);
            end
         end
         S_EMIT: begin
            rsp_data_in.point_count   = VCNT_W'(count_ff);
            rsp_data_in.edge_overflow = ovf_ff;
            rsp_data_in.none_found    = 1'b0;
            rsp_data_in.cut_vertex    = END_W'(scan_v);
            rsp_data_in.last_result   = (k_ff + NW'(1) == count_ff);
            if (count_ff == '0) begin
               rsp_strobe_in           = 1'b1;
               rsp_data_in.cut_vertex  = '0;
               rsp_data_in.none_found  = 1'b1;
               rsp_data_in.last_result = 1'b1;
               finish                  = 1'b1;
               state_in                = S_IDLE;
            end else if (scan_ff >= n_vert) begin
               finish   = 1'b1;
               state_in = S_IDLE;
            end else begin
               scan_in = scan_ff + NW'(1);
               if (cut_ff[scan_v]) begin
                  rsp_strobe_in = 1'b1;
                  k_in          = k_ff + NW'(1);
                  if (k_ff + NW'(1) == count_ff) begin
                     finish   = 1'b1;
                     state_in = S_IDLE;
                  end
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign busy       = (state_ff != S_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

endmodule

// ===== hw/rtl/articulation_point_finder.sv =====
// ----------------------------------------------------------------------------
// articulation_point_finder
// Loads graph edges, then finds and reports the cut vertices of the graph.
// An edge request leaves busy low, so the next request may follow.
// A compute request holds busy through a full edge store scan for each
// visited vertex, then through the count and the emission of the results.
// Results appear one per cycle at most; the receiver cannot stall them.
// Synchronous reset clears control state; vertex_count returns to 64.
// ----------------------------------------------------------------------------
module articulation_point_finder
   import apf_pkg::*;
#(
   parameter int MAX_VERTICES = DEF_MAX_VERTICES,
   parameter int MAX_EDGES    = DEF_MAX_EDGES
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  req_type           req_data,
   output logic              rsp_strobe,
   output rsp_type           rsp_data,
   input  logic              csr_we,
   input  logic [VCNT_W-1:0] csr_wdata
);

   localparam int NW  = $clog2(MAX_VERTICES+1);
   localparam int EAW = $clog2(MAX_EDGES);
   localparam int ECW = $clog2(MAX_EDGES+1);

   logic [VCNT_W-1:0] vcount_ff, vcount_in;
   logic [ECW-1:0] loaded_ff, loaded_in;
   logic dropped_ff, dropped_in;
   logic [NW-1:0] n_vert;
   logic accept, add, edge_ok, finish;
   logic [EAW-1:0] edge_raddr;
   logic [2*END_W-1:0] edge_rdata;
   run_ctl_type ctl;

   always_comb begin
      if (vcount_ff == '0) begin
         n_vert = NW'(1);
      end else if (int'(vcount_ff) > MAX_VERTICES) begin
         n_vert = NW'(MAX_VERTICES);
      end else begin
         n_vert = NW'(vcount_ff);
      end
   end

   assign accept  = start && !busy;
   assign add     = accept && ((req_data.func == FUNC_ADD) || (req_data.func == FUNC_ADD_RUN));
   assign edge_ok = (int'(req_data.end_a) < int'(n_vert)) &&
                    (int'(req_data.end_b) < int'(n_vert)) &&
                    (int'(loaded_ff) < MAX_EDGES);

   always_comb begin
      vcount_in  = csr_we ? csr_wdata : vcount_ff;
      loaded_in  = loaded_ff;
      dropped_in = dropped_ff;
      if (finish) begin
         loaded_in  = '0;
         dropped_in = 1'b0;
      end else if (add) begin
         if (edge_ok) begin
            loaded_in = loaded_ff + ECW'(1);
         end else begin
            dropped_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vcount_ff  <= VCOUNT_RESET;
         loaded_ff  <= '0;
         dropped_ff <= 1'b0;
      end else begin
         vcount_ff  <= vcount_in;
         loaded_ff  <= loaded_in;
         dropped_ff <= dropped_in;
      end
   end

   assign ctl.run     = accept && ((req_data.func == FUNC_ADD_RUN) ||
                                   (req_data.func == FUNC_RUN));
   assign ctl.dropped = dropped_in;

   apf_ram #(.DEPTH(MAX_EDGES), .WIDTH(2*END_W)) u_edges (
      .clock(clock), .wr_en(add && edge_ok), .wr_addr(loaded_ff[EAW-1:0]),
      .wr_data({req_data.end_a, req_data.end_b}),
      .rd_addr(edge_raddr), .rd_data(edge_rdata)
   );

   apf_search #(.MAX_VERTICES(MAX_VERTICES), .MAX_EDGES(MAX_EDGES)) u_search (
      .clock(clock), .reset(reset), .ctl(ctl), .n_vert(n_vert),
      .edges_loaded(loaded_ff), .edge_raddr(edge_raddr), .edge_rdata(edge_rdata),
      .busy(busy), .finish(finish), .rsp_strobe(rsp_strobe), .rsp_data(rsp_data)
   );

   a_none_last: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_data.none_found |-> rsp_data.last_result &&
      (rsp_data.point_count == '0))
      else $error("none_found result not final or count nonzero");

   a_run_busy: assert property (@(posedge clock) disable iff (reset)
      ctl.run |=> busy)
      else $error("compute request did not raise busy");

   a_no_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !busy |-> rsp_data.last_result)
      else $error("result after search finished is not the last");

endmodule
